[rtl/atl_pkg.sv]
// atl_pkg: shared types, constants and the arctangent table for the tilt angle block.
// Used by atl_front, atl_fifo, atl_back and accel_tilt_angles_with_tare.
// No dependencies.
package atl_pkg;

    // Field widths
    localparam int ACC_W   = 16;
    localparam int ANG_OUT = 8;

    // CORDIC datapath: inputs scaled by 2^14, 34-bit signed vector and Q30 angle
    localparam int IN_SHIFT = 14;
    localparam int VEC_W    = 34;
    localparam int ANG_W    = 34;
    localparam int TAB_LEN  = 24;
    localparam int TAB_IW   = 5;

    // Default number of CORDIC iterations (12..24)
    localparam int CORDIC_STEPS_DEF = 18;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    // pi/2 in Q30
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Scaling: t = ang * 4500 + 90 * 157 * 2^30, raw = t / (157 * 2^30)
    localparam int T_W = 48;
    localparam logic signed [T_W-1:0] T_OFS = 48'sd14130 <<< 30;
    localparam int U_W = 15;
    // ceil(2^24 / 157), exact for every u below 2^15
    localparam logic [16:0] RECIP_157 = 17'd106862;
    localparam int RECIP_SH = 24;
    localparam int PROD_W   = U_W + 17;
    localparam logic [ANG_OUT-1:0] ANG_MAX = 8'd180;

    // One operand pair of atan2(a, b)
    typedef struct packed {
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic                    zero;
    } t_pair;

    // One classified sample: pairs for yaw, pitch, roll (roll at index 0)
    typedef struct packed {
        t_pair [2:0] pairs;
        logic        tare;
    } t_item;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [30:0] atan_q30(input logic [TAB_IW-1:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/atl_front.sv]
// atl_front: input side; accepts sample beats and builds the three atan2 operand pairs.
// Depends on atl_pkg.
module atl_front (
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [47:0]               i_s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic                      i_s_tuser,   // tare_request[0]
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output atl_pkg::t_item            o_q_item
);

    logic signed [atl_pkg::ACC_W-1:0] w_x;
    logic signed [atl_pkg::ACC_W-1:0] w_y;
    logic signed [atl_pkg::ACC_W-1:0] w_z;
    logic signed [atl_pkg::ACC_W-1:0] w_ny;

    assign w_x = signed'(i_s_tdata[15:0]);
    assign w_y = signed'(i_s_tdata[31:16]);
    assign w_z = signed'(i_s_tdata[47:32]);

    // Negate y, saturating the most negative value
    assign w_ny = (w_y == 16'sh8000) ? 16'sh7FFF : -w_y;

    // Beat is taken whenever the queue has room
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

    // Roll (-y, z), pitch (z, x), yaw (x, y)
    always_comb begin
        o_q_item.pairs[0].a    = w_ny;
        o_q_item.pairs[0].b    = w_z;
        o_q_item.pairs[0].zero = (w_ny == '0) && (w_z == '0);
        o_q_item.pairs[1].a    = w_z;
        o_q_item.pairs[1].b    = w_x;
        o_q_item.pairs[1].zero = (w_z == '0) && (w_x == '0);
        o_q_item.pairs[2].a    = w_x;
        o_q_item.pairs[2].b    = w_y;
        o_q_item.pairs[2].zero = (w_x == '0) && (w_y == '0);
        o_q_item.tare          = i_s_tuser;
    end

endmodule

[rtl/atl_fifo.sv]
// atl_fifo: short queue of classified samples between front and back.
// Depends on atl_pkg.
module atl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atl_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output atl_pkg::t_item o_item
);

    localparam int PW = (atl_pkg::Q_DEPTH > 1) ? $clog2(atl_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(atl_pkg::Q_DEPTH + 1);

    atl_pkg::t_item r_mem [atl_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(atl_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(atl_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(atl_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/atl_back.sv]
// atl_back: shared vectoring CORDIC, angle scaling, tare and the output register.
// Depends on atl_pkg.
module atl_back #(
    parameter int CORDIC_STEPS = atl_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  atl_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [23:0]    o_m_tdata     // roll[7:0], pitch[15:8], yaw[23:16]
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int VW = atl_pkg::VEC_W;
    localparam int AW = atl_pkg::ANG_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_ITER = 7'b0000100,
        S_SCL1 = 7'b0001000,
        S_SCL2 = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    atl_pkg::t_item               r_item;
    logic [1:0]                   r_k;
    logic [IW-1:0]                r_iter;
    logic signed [VW-1:0]         r_x;
    logic signed [VW-1:0]         r_y;
    logic signed [AW-1:0]         r_ang;
    logic signed [atl_pkg::T_W-1:0] r_t;
    logic                         r_tpos;
    logic [atl_pkg::PROD_W-1:0]   r_prod;
    logic [7:0]                   r_last [3];
    logic [7:0]                   r_tare [3];
    logic [7:0]                   r_res  [3];
    logic                         r_out_valid;
    logic [23:0]                  r_out_data;

    atl_pkg::t_pair               w_pair;
    logic signed [VW-1:0]         w_a;
    logic signed [VW-1:0]         w_b;
    logic signed [VW-1:0]         w_dx;
    logic signed [VW-1:0]         w_dy;
    logic signed [AW-1:0]         w_atan;
    logic signed [atl_pkg::T_W-1:0] w_ang_ext;
    logic [7:0]                   w_q;
    logic [7:0]                   w_raw;
    logic [7:0]                   w_diff;
    logic                         w_out_load;

    // Operand pair scaled by 2^14
    assign w_pair = i_q_item.pairs[0];
    assign w_a    = {{(VW-atl_pkg::ACC_W-atl_pkg::IN_SHIFT){r_item.pairs[r_k].a[15]}},
                     r_item.pairs[r_k].a, {atl_pkg::IN_SHIFT{1'b0}}};
    assign w_b    = {{(VW-atl_pkg::ACC_W-atl_pkg::IN_SHIFT){r_item.pairs[r_k].b[15]}},
                     r_item.pairs[r_k].b, {atl_pkg::IN_SHIFT{1'b0}}};

    // CORDIC step terms
    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = signed'({{(AW-31){1'b0}}, atl_pkg::atan_q30(atl_pkg::TAB_IW'(r_iter))});

    // ang * 4500 as shift-adds: 4096 + 256 + 128 + 16 + 4
    assign w_ang_ext = {{(atl_pkg::T_W-AW){r_ang[AW-1]}}, r_ang};

    // Raw angle from the reciprocal product, clamped
    assign w_q   = r_prod[atl_pkg::RECIP_SH +: 8];
    assign w_raw = !r_tpos ? 8'd0 : ((w_q > atl_pkg::ANG_MAX) ? atl_pkg::ANG_MAX : w_q);
    assign w_diff = (w_raw >= r_tare[r_k]) ? (w_raw - r_tare[r_k]) : (r_tare[r_k] - w_raw);

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_PREP;
            S_PREP: n_state = r_item.pairs[r_k].zero ? S_SCL1 : S_ITER;
            S_ITER: if (r_iter == IW'(CORDIC_STEPS - 1)) n_state = S_SCL1;
            S_SCL1: n_state = S_SCL2;
            S_SCL2: n_state = S_FIN;
            S_FIN:  n_state = (r_k == 2'd2) ? S_DONE : S_PREP;
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_last[k] <= '0;
                r_tare[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_k <= '0;
                if (i_q_item.tare) begin
                    for (int k = 0; k < 3; k++) begin
                        r_tare[k] <= r_last[k];
                    end
                end
            end
            if (r_state == S_PREP) begin
                r_iter <= '0;
            end else if (r_state == S_ITER) begin
                r_iter <= r_iter + 1'b1;
            end
            if (r_state == S_FIN) begin
                r_last[r_k] <= w_raw;
                r_k         <= r_k + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        unique case (r_state)
            S_PREP: begin
                if (r_item.pairs[r_k].zero) begin
                    r_ang <= '0;
                end else if (w_b < 0) begin
                    // Rotate into the right half plane
                    if (w_a >= 0) begin
                        r_x   <= w_a;
                        r_y   <= -w_b;
                        r_ang <= atl_pkg::HALF_PI_Q30;
                    end else begin
                        r_x   <= -w_a;
                        r_y   <= w_b;
                        r_ang <= -atl_pkg::HALF_PI_Q30;
                    end
                end else begin
                    r_x   <= w_b;
                    r_y   <= w_a;
                    r_ang <= '0;
                end
            end
            S_ITER: begin
                if (r_y > 0) begin
                    r_x   <= r_x + w_dx;
                    r_y   <= r_y - w_dy;
                    r_ang <= r_ang + w_atan;
                end else begin
                    r_x   <= r_x - w_dx;
                    r_y   <= r_y + w_dy;
                    r_ang <= r_ang - w_atan;
                end
            end
            S_SCL1: begin
                r_t <= (w_ang_ext <<< 12) + (w_ang_ext <<< 8) + (w_ang_ext <<< 7)
                     + (w_ang_ext <<< 4) + (w_ang_ext <<< 2) + atl_pkg::T_OFS;
            end
            S_SCL2: begin
                r_tpos <= (r_t > 0);
                r_prod <= atl_pkg::PROD_W'(r_t[30 +: atl_pkg::U_W]) * atl_pkg::PROD_W'(atl_pkg::RECIP_157);
            end
            S_FIN: begin
                r_res[r_k] <= w_diff;
            end
            S_IDLE, S_DONE: begin
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_data <= {r_res[2], r_res[1], r_res[0]};
        end
    end

    // Assertions
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_iter <= IW'(CORDIC_STEPS - 1)))
        else $error("CORDIC iteration count out of range");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_k <= 2'd2))
        else $error("angle index out of range");

    a_raw_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last[0] <= atl_pkg::ANG_MAX) && (r_last[1] <= atl_pkg::ANG_MAX)
        && (r_last[2] <= atl_pkg::ANG_MAX))
        else $error("raw angle above limit");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_PREP) && (r_k == 2'd0))
        else $error("pop did not start a new sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_m_tready |=> (r_state == S_DONE))
        else $error("result overwrote a stalled beat");

    // Pair zero flag is only a front-end hint; check the roll pair's flag matches its operands
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (w_pair.zero == ((w_pair.a == '0) && (w_pair.b == '0))))
        else $error("zero flag does not match roll operands");

endmodule

[rtl/accel_tilt_angles_with_tare.sv]
// Tilt angles (roll, pitch, yaw, 0..180) from one accelerometer sample, relative to a tare.
// Samples are processed one at a time: the one shared CORDIC runs the three angles in turn,
// and a new sample is popped from the queue only after the last one has gone to the output
// register; a two-entry queue and the output register let input and output stall
// independently.
// Reset (synchronous, active low) empties the queue and clears stored and tare angles to 0.
module accel_tilt_angles_with_tare #(
    parameter int CORDIC_STEPS = atl_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic        i_s_tuser,   // tare_request[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // roll_angle[7:0], pitch_angle[15:8], yaw_angle[23:16]
);

    logic           w_q_full;
    logic           w_q_push;
    atl_pkg::t_item w_push_item;
    logic           w_q_valid;
    logic           w_q_pop;
    atl_pkg::t_item w_pop_item;

    atl_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_item   (w_push_item)
    );

    atl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    atl_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_pop_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
